// ===== hw/rtl/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types, constants and the sample encoder for the PCM16 channel remap.
// ----------------------------------------------------------------------------
package pce_pkg;

    localparam int OUT_CHANNELS = 2;
    localparam int MASK_BITS    = 32;
    localparam int CH_W         = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int POS_W        = 6;
    localparam int ADDR_W       = 4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MASK   = 2'd0;
    localparam logic [1:0] REG_BUFFER = 2'd1;
    localparam logic [1:0] REG_START  = 2'd2;

    typedef struct packed {
        logic [31:0]             sample_bits;
        logic [OUT_CHANNELS-1:0] emit;   // channels that produce a word
        logic [OUT_CHANNELS-1:0] hit;    // channel that carries the sample
        logic [15:0]             fw;
    } queue_entry_t;

    typedef struct packed {
        logic [MASK_BITS-1:0] mask;
        logic [15:0]          buffer_frames;
        logic [15:0]          start_frame;
    } cfg_t;

    // float32 -> x*32768, clamp, truncate toward zero, byte swap
    function automatic logic [15:0] encode_sample(input logic [31:0] bits);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [4:0]  sh;
        logic [23:0] shifted;
        logic [15:0] val;
        sgn = bits[31];
        ex  = bits[30:23];
        man = bits[22:0];
        sh  = 5'd0;
        shifted = 24'd0;
        if (ex == 8'hFF && man != 23'd0) begin
            val = 16'h0000;
        end else if (ex >= 8'd127) begin
            val = sgn ? 16'h8000 : 16'h7FFF;
        end else if (ex < 8'd112) begin
            val = 16'h0000;
        end else begin
            sh      = ex[4:0] - 5'd16;           // ex - 112, range 0..14
            shifted = {1'b1, man} >> (5'd23 - sh);
            val     = {1'b0, shifted[14:0]};
            if (sgn) begin
                val = 16'd0 - val;
            end
        end
        return {val[7:0], val[15:8]};
    endfunction

endpackage

// ===== hw/rtl/pce_if.sv =====
// ----------------------------------------------------------------------------
// smp_if / pcm_if
// Valid/ready channels for input samples and output PCM words.
// ----------------------------------------------------------------------------
interface smp_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_bits;
    logic        batch_last;

    modport source (output valid, output sample_bits, output batch_last, input ready);
    modport sink   (input valid, input sample_bits, input batch_last, output ready);
endinterface

interface pcm_if;
    logic        valid;
    logic        ready;
    logic [15:0] pcm_word;
    logic        out_channel;
    logic        frame_end;
    logic        run_last;
    logic [15:0] frames_written;

    modport source (output valid, output pcm_word, output out_channel, output frame_end,
                    output run_last, output frames_written, input ready);
    modport sink   (input valid, input pcm_word, input out_channel, input frame_end,
                    input run_last, input frames_written, output ready);
endinterface

// ===== hw/rtl/pce_front.sv =====
// ----------------------------------------------------------------------------
// pce_front
// Accepts samples, tracks frame position and count, classifies output words.
// ----------------------------------------------------------------------------
module pce_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pce_pkg::cfg_t         cfg,
    smp_if.sink                   sample_in,
    output logic                  push_valid,
    input  logic                  push_ready,
    output pce_pkg::queue_entry_t push_entry
);
    import pce_pkg::*;

    logic [POS_W-1:0]     chan_pos_reg, chan_pos_next;
    logic [15:0]          frames_done_reg, frames_done_next;
    logic [MASK_BITS-1:0] m, masked;
    logic [POS_W-1:0]     pos, c;
    logic                 more, keep, accept;
    logic [15:0]          off, cap, fw;

    assign m = cfg.mask;
    assign sample_in.ready = push_ready;
    assign accept = sample_in.valid && sample_in.ready;

    always_comb
    begin
        off  = (cfg.start_frame > cfg.buffer_frames) ? cfg.buffer_frames : cfg.start_frame;
        cap  = cfg.buffer_frames - off;
        keep = frames_done_reg < cap;
        fw   = (frames_done_reg != 16'hFFFF) ? frames_done_reg + 16'd1 : 16'hFFFF;
        pos  = ((m >> chan_pos_reg) == '0) ? '0 : chan_pos_reg;
        masked = m & ({MASK_BITS{1'b1}} << pos);
        c = '0;
        for (int i = MASK_BITS - 1; i >= 0; i--) begin
            if (masked[i]) begin
                c = POS_W'(i);
            end
        end
        more = (masked & ~({{(MASK_BITS-1){1'b0}}, 1'b1} << c)) != '0;

        push_entry.sample_bits = sample_in.sample_bits;
        push_entry.fw          = fw;
        for (int ch = 0; ch < OUT_CHANNELS; ch++) begin
            push_entry.emit[ch] = (m != '0) && keep && (POS_W'(ch) >= pos)
                                  && ((POS_W'(ch) <= c) || !more);
            push_entry.hit[ch]  = (POS_W'(ch) == c);
        end
        push_valid = sample_in.valid && (push_entry.emit != '0);

        chan_pos_next    = chan_pos_reg;
        frames_done_next = frames_done_reg;
        if (m != '0) begin
            if (more) begin
                chan_pos_next = c + POS_W'(1);
            end else begin
                chan_pos_next    = '0;
                frames_done_next = fw;
            end
        end
        if (sample_in.batch_last) begin
            chan_pos_next    = '0;
            frames_done_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            chan_pos_reg    <= '0;
            frames_done_reg <= '0;
        end else if (accept) begin
            chan_pos_reg    <= chan_pos_next;
            frames_done_reg <= frames_done_next;
        end
    end

endmodule

// ===== hw/rtl/pce_queue.sv =====
// ----------------------------------------------------------------------------
// pce_queue
// Two-entry queue between the classifier and the word emitter.
// ----------------------------------------------------------------------------
module pce_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  pce_pkg::queue_entry_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output pce_pkg::queue_entry_t pop_entry
);
    import pce_pkg::*;

    queue_entry_t mem_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_push, do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/pce_back.sv =====
// ----------------------------------------------------------------------------
// pce_back
// Walks the queued word mask, encodes the sample, drives the output register.
// ----------------------------------------------------------------------------
module pce_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  pce_pkg::queue_entry_t pop_entry,
    pcm_if.source                 pcm_out
);
    import pce_pkg::*;

    logic [OUT_CHANNELS-1:0] done_reg, done_next;
    logic [OUT_CHANNELS-1:0] remaining, sel_bit;
    logic [CH_W-1:0]         ch;
    logic                    valid_reg;
    logic [15:0]             word_reg;
    logic [CH_W-1:0]         ch_reg;
    logic                    last_reg;
    logic [15:0]             fw_reg;
    logic                    load, is_last;

    assign load = !valid_reg || pcm_out.ready;

    always_comb
    begin
        remaining = pop_entry.emit & ~done_reg;
        ch = '0;
        for (int i = OUT_CHANNELS - 1; i >= 0; i--) begin
            if (remaining[i]) begin
                ch = CH_W'(i);
            end
        end
        sel_bit   = {{(OUT_CHANNELS-1){1'b0}}, 1'b1} << ch;
        is_last   = (remaining & ~sel_bit) == '0;
        pop_ready = load && is_last;
        done_next = done_reg;
        if (load && pop_valid) begin
            done_next = is_last ? '0 : (done_reg | sel_bit);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && pop_valid) begin
            word_reg <= (pop_entry.hit[ch]) ? encode_sample(pop_entry.sample_bits) : 16'h0000;
            ch_reg   <= ch;
            last_reg <= is_last;
            fw_reg   <= pop_entry.fw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                valid_reg <= pop_valid;
            end
        end
    end

    assign pcm_out.valid          = valid_reg;
    assign pcm_out.pcm_word       = word_reg;
    assign pcm_out.out_channel    = ch_reg[0];
    assign pcm_out.frame_end      = ch_reg == CH_W'(OUT_CHANNELS - 1);
    assign pcm_out.run_last       = last_reg;
    assign pcm_out.frames_written = fw_reg;

endmodule

// ===== hw/rtl/pcm16_encode_channel_remap.sv =====
// ----------------------------------------------------------------------------
// pcm16_encode_channel_remap
// Float32 samples to big-endian PCM16 frames with channel remapping.
// ----------------------------------------------------------------------------
// An accepted sample goes to the queue, then to the output register.
// Throughput: one output word per cycle while pcm_out.ready is high, so a
//   sample making two words holds the emitter for both; samples are taken
//   back to back while the two-entry queue has room.
// Reset: rst_n async low clears counters, queue and output valid; mask=1.
module pcm16_encode_channel_remap (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pce_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    smp_if.sink                        sample_in,
    pcm_if.source                      pcm_out
);
    import pce_pkg::*;

    cfg_t         cfg_reg;
    logic         push_valid, push_ready, pop_valid, pop_ready;
    queue_entry_t push_entry, pop_entry;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.mask          <= MASK_BITS'(1);
            cfg_reg.buffer_frames <= '0;
            cfg_reg.start_frame   <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_MASK:   cfg_reg.mask          <= pwdata[MASK_BITS-1:0];
                REG_BUFFER: cfg_reg.buffer_frames <= pwdata[15:0];
                REG_START:  cfg_reg.start_frame   <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MASK:   prdata = cfg_reg.mask;
            REG_BUFFER: prdata = {16'd0, cfg_reg.buffer_frames};
            REG_START:  prdata = {16'd0, cfg_reg.start_frame};
            default:    prdata = 32'd0;
        endcase
    end

    pce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .sample_in  (sample_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    pce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    pce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .pcm_out   (pcm_out)
    );

endmodule

// ===== hw/rtl/pce_checker.sv =====
// ----------------------------------------------------------------------------
// pce_port_checker
// Port-level checks for the PCM16 channel remap, bound to the top level.
// ----------------------------------------------------------------------------
module pce_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        frame_end,
    input logic        run_last,
    input logic [15:0] frames_written
);
    import pce_pkg::*;

    // a stalled word stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped under stall");

    // second word of a transaction follows right away
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid && frame_end)
        else $error("second word of a transaction did not follow");

    // a word that is not last within its transaction is never a frame end
    a_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> !frame_end)
        else $error("frame end on a non-final word");

    // both words of a transaction belong to the same frame count
    a_fw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> frames_written == $past(frames_written))
        else $error("frame count changed within a transaction");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind pcm16_encode_channel_remap pce_port_checker u_pce_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pready         (pready),
    .out_valid      (pcm_out.valid),
    .out_ready      (pcm_out.ready),
    .frame_end      (pcm_out.frame_end),
    .run_last       (pcm_out.run_last),
    .frames_written (pcm_out.frames_written)
);
